>>> sv/tkt_pkg.sv
`timescale 1ns / 1ps
package tkt_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] term_byte;
    logic [7:0] bus_address;
    logic [2:0] access_size;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        dropped;
  } out_item_t;

  // Command codes passed from the front end to the back end
  localparam logic [2:0] OP_CONST    = 3'd0;  // result is {8'h00, code}, nothing else
  localparam logic [2:0] OP_KEY      = 3'd1;  // queue one key sequence
  localparam logic [2:0] OP_POP_BYTE = 3'd2;  // pop head word, low byte
  localparam logic [2:0] OP_POP_WORD = 3'd3;  // pop head word
  localparam logic [2:0] OP_DRAIN    = 3'd4;  // drain queue into direction bits

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] code;
    logic       alt;
    logic       ctrl;
    logic       shift;
  } cmd_t;

endpackage

>>> sv/tkt_front.sv
`timescale 1ns / 1ps
module tkt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tkt_pkg::in_item_t item,
  input  logic             q_full,
  output logic             busy,
  output logic             q_push,
  output tkt_pkg::cmd_t    q_cmd
);
  import tkt_pkg::*;

  localparam logic [7:0] ESC_IDLE = 8'h00;
  localparam logic [7:0] ESC_ESC  = 8'h1b;
  localparam logic [7:0] ESC_CSI  = 8'h5b;

  localparam logic [7:0] ADDR_KEY    = 8'd0;
  localparam logic [7:0] ADDR_LCD    = 8'd4;
  localparam logic [7:0] ADDR_OLDKEY = 8'd16;

  typedef struct packed {
    logic [7:0] code;
    logic       ctrl;
    logic       shift;
  } plain_t;

  logic [7:0] esc;
  logic [7:0] esc_next;

  logic [7:0] b;
  logic       is_digit;
  logic [6:0] num_n;
  logic [1:0] num_r;
  logic [6:0] num_v;
  logic [7:0] code;
  logic       alt, ctrl, shift;
  plain_t     pm;

  // n mod 3 for a 7-bit value, by conditional subtraction
  function automatic logic [1:0] mod3(input logic [6:0] n);
    logic [6:0] r;
    r = n;
    if (r >= 7'd96) r = r - 7'd96;
    if (r >= 7'd48) r = r - 7'd48;
    if (r >= 7'd24) r = r - 7'd24;
    if (r >= 7'd12) r = r - 7'd12;
    if (r >= 7'd6)  r = r - 7'd6;
    if (r >= 7'd3)  r = r - 7'd3;
    return r[1:0];
  endfunction

  // special-code table for ESC [ n ~ style sequences
  function automatic logic [7:0] numpad(input logic [4:0] n);
    logic [7:0] c;
    unique case (n)
      5'd1:    c = 8'h24;  // $
      5'd2:    c = 8'h2d;  // -
      5'd3:    c = 8'h2e;  // .
      5'd4:    c = 8'h23;  // #
      5'd5:    c = 8'h21;  // !
      5'd6:    c = 8'h22;  // "
      5'd11:   c = 8'h70;  // p
      5'd12:   c = 8'h71;
      5'd13:   c = 8'h72;
      5'd14:   c = 8'h73;
      5'd15:   c = 8'h74;  // t
      5'd17:   c = 8'h75;  // u
      5'd18:   c = 8'h76;
      5'd19:   c = 8'h77;
      5'd20:   c = 8'h78;
      5'd21:   c = 8'h79;  // y
      5'd23:   c = 8'h7a;  // z
      5'd24:   c = 8'h7b;  // {
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  // plain byte to key code plus ctrl/shift
  function automatic plain_t map_plain(input logic [7:0] bv);
    plain_t     p;
    logic [7:0] c40;
    p.code  = bv;
    p.ctrl  = 1'b0;
    p.shift = 1'b0;
    c40     = bv + 8'h40;
    if ((bv < 8'h20 || bv[7]) && bv != 8'h09 && bv != 8'h0d) begin
      if (c40 == 8'h4a) begin
        p.code = 8'h0d;          // Ctrl-J is Enter
      end else begin
        p.ctrl = 1'b1;
        p.code = c40;
      end
    end else if (bv >= 8'h41 && bv <= 8'h5a) begin
      p.shift = 1'b1;
    end else if (bv >= 8'h61 && bv <= 8'h7a) begin
      p.code = bv - 8'h20;
    end else begin
      unique case (bv)
        8'h29: begin p.code = 8'h30; p.shift = 1'b1; end  // )
        8'h21: begin p.code = 8'h31; p.shift = 1'b1; end  // !
        8'h40: begin p.code = 8'h32; p.shift = 1'b1; end  // @
        8'h23: begin p.code = 8'h33; p.shift = 1'b1; end  // #
        8'h24: begin p.code = 8'h34; p.shift = 1'b1; end  // $
        8'h25: begin p.code = 8'h35; p.shift = 1'b1; end  // %
        8'h5e: begin p.code = 8'h36; p.shift = 1'b1; end  // ^
        8'h26: begin p.code = 8'h37; p.shift = 1'b1; end  // &
        8'h2a: begin p.code = 8'h38; p.shift = 1'b1; end  // *
        8'h28: begin p.code = 8'h39; p.shift = 1'b1; end  // (
        8'h3b: p.code = 8'hba;                            // ;
        8'h3d: p.code = 8'hbb;                            // =
        8'h2c: p.code = 8'hbc;                            // ,
        8'h2d: p.code = 8'hbd;                            // -
        8'h2e: p.code = 8'hbe;                            // .
        8'h2f: p.code = 8'hbf;                            // /
        8'h60: p.code = 8'hc0;                            // `
        8'h3a: begin p.code = 8'hba; p.shift = 1'b1; end  // :
        8'h2b: begin p.code = 8'hbb; p.shift = 1'b1; end  // +
        8'h3c: begin p.code = 8'hbc; p.shift = 1'b1; end  // <
        8'h5f: begin p.code = 8'hbd; p.shift = 1'b1; end  // _
        8'h3e: begin p.code = 8'hbe; p.shift = 1'b1; end  // >
        8'h3f: begin p.code = 8'hbf; p.shift = 1'b1; end  // ?
        8'h7e: begin p.code = 8'hc0; p.shift = 1'b1; end  // ~
        8'h5b: p.code = 8'hdb;                            // [
        8'h5c: p.code = 8'hdc;                            // backslash
        8'h5d: p.code = 8'hdd;                            // ]
        8'h27: p.code = 8'hde;                            // '
        8'h7b: begin p.code = 8'hdb; p.shift = 1'b1; end  // {
        8'h7c: begin p.code = 8'hdc; p.shift = 1'b1; end  // |
        8'h7d: begin p.code = 8'hdd; p.shift = 1'b1; end  // }
        8'h22: begin p.code = 8'hde; p.shift = 1'b1; end  // "
        8'h7f: p.code = 8'h08;                            // DEL is backspace
        default: p.code = bv;
      endcase
    end
    return p;
  endfunction

  assign busy   = q_full;
  assign q_push = start && !q_full;

  assign b        = item.term_byte;
  assign is_digit = (b >= 8'h30) && (b <= 8'h39);
  assign num_n    = esc[6:0];
  assign num_r    = mod3(num_n);
  assign num_v    = 7'(num_r) * 7'd10 + {3'b000, b[3:0]};
  assign pm       = map_plain(b);

  always_comb begin
    esc_next = esc;
    code     = 8'h00;
    alt      = 1'b0;
    ctrl     = 1'b0;
    shift    = 1'b0;
    q_cmd    = '0;
    q_cmd.op = OP_CONST;
    if (item.action) begin
      if (item.access_size == 3'd1) begin
        priority if (item.bus_address == ADDR_LCD) begin
          q_cmd.code = 8'h01;
        end else if (item.bus_address == ADDR_KEY) begin
          q_cmd.op = OP_POP_BYTE;
        end else if (item.bus_address == ADDR_OLDKEY) begin
          q_cmd.op = OP_DRAIN;
        end
      end else if (item.access_size == 3'd4 && item.bus_address == ADDR_KEY) begin
        q_cmd.op = OP_POP_WORD;
      end
    end else if (b != 8'h00) begin
      priority if (b == ESC_ESC) begin
        code     = (esc == ESC_ESC) ? ESC_ESC : 8'h00;
        esc_next = ESC_ESC;
      end else if (esc == ESC_ESC && b == ESC_CSI) begin
        esc_next = ESC_CSI;
      end else if (esc == ESC_CSI) begin
        esc_next = ESC_IDLE;
        priority if (b == 8'h44) code = 8'h25;      // D left
        else if (b == 8'h41) code = 8'h26;          // A up
        else if (b == 8'h43) code = 8'h27;          // C right
        else if (b == 8'h42) code = 8'h28;          // B down
        else if (is_digit) esc_next = {4'h8, b[3:0]};
        else code = b;                              // raw, no modifiers
      end else if (esc[7]) begin
        if (is_digit) begin
          esc_next = {1'b1, num_v};
        end else begin
          code     = numpad(num_n[4:0]);
          esc_next = ESC_IDLE;
        end
      end else begin
        alt      = (esc == ESC_ESC);
        esc_next = ESC_IDLE;
        code     = pm.code;
        ctrl     = pm.ctrl;
        shift    = pm.shift;
      end
      if (code != 8'h00) begin
        q_cmd.op    = OP_KEY;
        q_cmd.code  = code;
        q_cmd.alt   = alt;
        q_cmd.ctrl  = ctrl;
        q_cmd.shift = shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc <= ESC_IDLE;
    end else if (q_push) begin
      esc <= esc_next;
    end
  end

endmodule

>>> sv/tkt_cmdq.sv
`timescale 1ns / 1ps
module tkt_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tkt_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output tkt_pkg::cmd_t rd_cmd,
  output logic          full,
  output logic          empty
);
  import tkt_pkg::*;

  cmd_t       slots [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full   = (cnt == 2'd2);
  assign empty  = (cnt == 2'd0);
  assign rd_cmd = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

>>> sv/tkt_back.sv
`timescale 1ns / 1ps
module tkt_back #(
  parameter int KEY_SLOTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  tkt_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  output logic                           done,
  output tkt_pkg::out_item_t             result,
  output logic [$clog2(KEY_SLOTS+1)-1:0] fill_level
);
  import tkt_pkg::*;

  localparam int AW = $clog2(KEY_SLOTS);
  localparam int CW = $clog2(KEY_SLOTS + 1);
  localparam logic [AW-1:0] LAST  = AW'(KEY_SLOTS - 1);
  localparam logic [CW:0]   SLOTS = (CW+1)'(KEY_SLOTS);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PUSH     = 3'd1;
  localparam logic [2:0] S_POP_WAIT = 3'd2;
  localparam logic [2:0] S_POP      = 3'd3;
  localparam logic [2:0] S_DRN_WAIT = 3'd4;
  localparam logic [2:0] S_DRN      = 3'd5;

  localparam logic [15:0] ALT_MAKE    = 16'h00a4;
  localparam logic [15:0] CTRL_MAKE   = 16'h00a2;
  localparam logic [15:0] SHIFT_MAKE  = 16'h00a0;
  localparam logic [15:0] SHIFT_BREAK = 16'ha000;
  localparam logic [15:0] CTRL_BREAK  = 16'ha200;
  localparam logic [15:0] ALT_BREAK   = 16'ha400;

  logic [15:0]   mem [KEY_SLOTS];
  logic [15:0]   rd_data;
  logic [2:0]    state;
  logic [AW-1:0] head, tail;
  logic [CW-1:0] fill;
  logic [2:0]    step;
  cmd_t          cur;
  logic [5:0]    bits;
  logic [15:0]   word;
  logic          wen;
  logic [3:0]    need;
  logic [CW:0]   fill_sum;
  logic [5:0]    dir;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  assign fill_level = fill;
  assign q_pop      = (state == S_IDLE) && !q_empty;
  assign need       = {1'b0, 2'(q_cmd.alt) + 2'(q_cmd.ctrl) + 2'(q_cmd.shift), 1'b0} + 4'd2;
  assign fill_sum   = {1'b0, fill} + (CW+1)'(need);

  // direction bits for the oldkey drain
  always_comb begin
    unique case (rd_data[7:0])
      8'h57:   dir = 6'd32;  // W
      8'h53:   dir = 6'd16;  // S
      8'h41:   dir = 6'd8;   // A
      8'h44:   dir = 6'd4;   // D
      8'h4a:   dir = 6'd2;   // J
      8'h4b:   dir = 6'd1;   // K
      default: dir = 6'd0;
    endcase
  end

  // make/break word for each slot of the sequence
  always_comb begin
    unique case (step)
      3'd0:    begin wen = cur.alt;   word = ALT_MAKE;          end
      3'd1:    begin wen = cur.ctrl;  word = CTRL_MAKE;         end
      3'd2:    begin wen = cur.shift; word = SHIFT_MAKE;        end
      3'd3:    begin wen = 1'b1;      word = {8'h00, cur.code}; end
      3'd4:    begin wen = 1'b1;      word = {cur.code, 8'h00}; end
      3'd5:    begin wen = cur.shift; word = SHIFT_BREAK;       end
      3'd6:    begin wen = cur.ctrl;  word = CTRL_BREAK;        end
      default: begin wen = cur.alt;   word = ALT_BREAK;         end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH && wen) begin
      mem[tail] <= word;
    end
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur    <= q_cmd;
            result <= '0;
            unique case (q_cmd.op)
              OP_KEY: begin
                if (fill_sum > SLOTS) begin
                  done           <= 1'b1;
                  result.dropped <= 1'b1;
                end else begin
                  step  <= '0;
                  state <= S_PUSH;
                end
              end
              OP_POP_BYTE, OP_POP_WORD: begin
                if (fill == '0) done <= 1'b1;
                else state <= S_POP_WAIT;
              end
              OP_DRAIN: begin
                bits <= '0;
                if (fill == '0) done <= 1'b1;
                else state <= S_DRN_WAIT;
              end
              default: begin
                done             <= 1'b1;
                result.read_data <= {8'h00, q_cmd.code};
              end
            endcase
          end
        end
        S_PUSH: begin
          if (wen) begin
            tail <= ptr_inc(tail);
            fill <= fill + CW'(1);
          end
          step <= step + 3'd1;
          if (step == 3'd7) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_POP_WAIT: state <= S_POP;
        S_POP: begin
          result.read_data <= (cur.op == OP_POP_BYTE) ? {8'h00, rd_data[7:0]} : rd_data;
          head  <= ptr_inc(head);
          fill  <= fill - CW'(1);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_DRN_WAIT: state <= S_DRN;
        S_DRN: begin
          bits <= bits | dir;
          head <= ptr_inc(head);
          fill <= fill - CW'(1);
          if (fill == CW'(1)) begin
            result.read_data <= {10'b0, bits | dir};
            done             <= 1'b1;
            state            <= S_IDLE;
          end else begin
            state <= S_DRN_WAIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/terminal_key_translator_fifo.sv
`timescale 1ns / 1ps
// Status, invalid and empty-queue reads, bytes that make no key and dropped sequences
//   finish in S_IDLE; a queued key steps S_PUSH over its make/break slots; a pop goes
//   S_POP_WAIT, S_POP; the oldkey drain loops S_DRN_WAIT, S_DRN once per queue word.
// Throughput is set by the back end; the two-entry command queue lets the front take
//   up to two beats ahead. The receiver cannot stall: done is a one-cycle strobe.
// Reset (rst, synchronous) clears escape state, command queue and key fill; no clearing pass.
module terminal_key_translator_fifo #(
  parameter int KEY_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tkt_pkg::in_item_t  item,
  output logic               busy,
  output logic               done,
  output tkt_pkg::out_item_t result
);
  import tkt_pkg::*;

  localparam int CW = $clog2(KEY_SLOTS + 1);

  // front -> queue
  logic q_push;
  cmd_t q_wr_cmd;
  // queue -> back
  logic q_pop;
  cmd_t q_rd_cmd;
  logic q_full;
  logic q_empty;

  logic [CW-1:0] fill_level;

  // Front end: escape-sequence decoding and key mapping, one beat per cycle
  // while the command queue has room.
  tkt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .q_full (q_full),
    .busy   (busy),
    .q_push (q_push),
    .q_cmd  (q_wr_cmd)
  );

  // Short command queue decoupling decode from queue maintenance.
  tkt_cmdq u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .pop    (q_pop),
    .rd_cmd (q_rd_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  // Back end: ring-buffer key queue; pushes make/break sequences, pops and drains.
  tkt_back #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (q_rd_cmd),
    .q_pop      (q_pop),
    .done       (done),
    .result     (result),
    .fill_level (fill_level)
  );

  // Key queue never holds more words than it has slots.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= CW'(KEY_SLOTS))
    else $error("key fill exceeds slot count");

  // A dropped sequence reports no read data.
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.dropped |-> result.read_data == 16'h0000)
    else $error("dropped result carries data");

  // Front is only held off by a full command queue.
  a_busy_q: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !busy)
    else $error("busy with empty command queue");

  // Back end pops only what the queue holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty command queue");

endmodule

>>> verif/tb_terminal_key_translator_fifo.sv
`timescale 1ns / 1ps
module tb_terminal_key_translator_fifo;
  import tkt_pkg::*;

  localparam int KEY_SLOTS   = 64;
  // Slowest legal beat is a full-queue oldkey drain plus a long
  // sender gap; ~650 beats of that fit well inside this bound.
  localparam int CYCLE_LIMIT = 600_000;
  localparam int TAIL_CYCLES = 200;

  // Item kinds
  localparam logic ACT_TERM = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Bus register offsets and access sizes
  localparam logic [7:0] ADDR_KEY    = 8'd0;
  localparam logic [7:0] ADDR_LCD    = 8'd4;
  localparam logic [7:0] ADDR_OLDKEY = 8'd16;
  localparam logic [7:0] ADDR_BOGUS  = 8'hff;
  localparam logic [2:0] SIZE_BYTE   = 3'd1;
  localparam logic [2:0] SIZE_HALF   = 3'd2;
  localparam logic [2:0] SIZE_WORD   = 3'd4;

  // Terminal bytes with special meaning
  localparam logic [7:0] KC_ESC = 8'h1b;
  localparam logic [7:0] KC_CSI = 8'h5b;
  localparam logic [7:0] KC_TAB = 8'h09;
  localparam logic [7:0] KC_CR  = 8'h0d;
  localparam logic [7:0] KC_LF  = 8'h0a;
  localparam logic [7:0] KC_DEL = 8'h7f;
  localparam logic [7:0] KC_BS  = 8'h08;
  localparam logic [7:0] KC_NUL = 8'h00;

  // Escape state for numeric codes, and key code bases
  localparam logic [7:0] NUM_BASE   = 8'h80;
  localparam logic [7:0] ARROW_BASE = 8'h25;
  localparam logic [7:0] PUNCT_BASE = 8'hba;
  localparam logic [7:0] BRACK_BASE = 8'hdb;

  // Modifier make codes; break word is the code in the high byte
  localparam logic [7:0] ALT_MAKE   = 8'ha4;
  localparam logic [7:0] CTRL_MAKE  = 8'ha2;
  localparam logic [7:0] SHIFT_MAKE = 8'ha0;

  logic       clk   = 1'b0;
  logic       rst   = 1'b1;
  logic       start = 1'b0;
  in_item_t   item  = '0;
  logic       busy;
  logic       done;
  out_item_t  result;

  // Predictor state: escape machine and key-word queue (head at index 0)
  logic [7:0]  esc_state = 8'h00;
  logic [15:0] key_words[$];

  out_item_t   expected_results[$];
  int          fail_count  = 0;
  int          sent_count  = 0;
  int          idle_pct    = 0;
  int          cycle_count = 0;

  always #4 clk = ~clk;

  terminal_key_translator_fifo #(
    .KEY_SLOTS(KEY_SLOTS)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  // ---------------------------------------------------------------------------
  // Key translation tables
  // ---------------------------------------------------------------------------

  // Shifted digit row: ")!@#$%^&*(" -> '0'..'9'
  function automatic int shifted_digit_index(logic [7:0] c);
    case (c)
      ")": return 0;
      "!": return 1;
      "@": return 2;
      "#": return 3;
      "$": return 4;
      "%": return 5;
      "^": return 6;
      "&": return 7;
      "*": return 8;
      "(": return 9;
      default: return -1;
    endcase
  endfunction

  // Punctuation: seven plain at indices 0-6, seven shifted at 8-14
  function automatic int punct_index(logic [7:0] c);
    case (c)
      ";":   return 0;
      "=":   return 1;
      ",":   return 2;
      "-":   return 3;
      ".":   return 4;
      "/":   return 5;
      8'h60: return 6;
      ":":   return 8;
      "+":   return 9;
      "<":   return 10;
      "_":   return 11;
      ">":   return 12;
      "?":   return 13;
      "~":   return 14;
      default: return -1;
    endcase
  endfunction

  // Brackets and quotes: [ \ ] ' plain, { | } " shifted
  function automatic int bracket_index(logic [7:0] c);
    case (c)
      "[":   return 0;
      8'h5c: return 1;
      "]":   return 2;
      8'h27: return 3;
      "{":   return 4;
      "|":   return 5;
      "}":   return 6;
      8'h22: return 7;
      default: return -1;
    endcase
  endfunction

  // Arrow letters after ESC-[ in order D A C B
  function automatic int arrow_index(logic [7:0] c);
    case (c)
      "D": return 0;
      "A": return 1;
      "C": return 2;
      "B": return 3;
      default: return -1;
    endcase
  endfunction

  // Numeric code lookup; unlisted slots are blanks
  function automatic logic [7:0] numpad_char(logic [4:0] n);
    case (n)
      5'd1:  return "$";
      5'd2:  return "-";
      5'd3:  return ".";
      5'd4:  return "#";
      5'd5:  return "!";
      5'd6:  return 8'h22;
      5'd11: return "p";
      5'd12: return "q";
      5'd13: return "r";
      5'd14: return "s";
      5'd15: return "t";
      5'd17: return "u";
      5'd18: return "v";
      5'd19: return "w";
      5'd20: return "x";
      5'd21: return "y";
      5'd23: return "z";
      5'd24: return "{";
      default: return " ";
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One terminal byte; returns the dropped flag
  function automatic logic translate_byte(logic [7:0] b);
    logic       alt;
    logic       ctrl;
    logic       shift;
    logic       is_digit;
    logic [7:0] code;
    logic [7:0] n;
    int         k;
    int         need;
    alt      = 1'b0;
    ctrl     = 1'b0;
    shift    = 1'b0;
    code     = b;
    is_digit = (b >= "0" && b <= "9");
    if (b == KC_NUL) return 1'b0;   // NUL leaves even the escape state alone

    if (b == KC_ESC) begin
      // double ESC yields a plain ESC key; ESC mid-sequence restarts
      code      = (esc_state == KC_ESC) ? KC_ESC : 8'h00;
      esc_state = KC_ESC;
    end else if (esc_state == KC_ESC && b == KC_CSI) begin
      esc_state = KC_CSI;
      code      = 8'h00;
    end else if (esc_state == KC_CSI) begin
      k = arrow_index(b);
      if (k >= 0) begin
        esc_state = 8'h00;
        code      = ARROW_BASE + 8'(k);
      end else if (is_digit) begin
        esc_state = NUM_BASE + (b - "0");
        code      = 8'h00;
      end else begin
        esc_state = 8'h00;          // raw byte, unmapped, no modifiers
      end
    end else if (esc_state >= NUM_BASE) begin
      n = (esc_state - NUM_BASE) & 8'h7f;
      if (is_digit) begin
        esc_state = NUM_BASE + 8'((n % 3) * 10) + (b - "0");
        code      = 8'h00;
      end else begin
        code      = numpad_char(n[4:0]);   // terminator is consumed
        esc_state = 8'h00;
      end
    end else begin
      alt       = (esc_state == KC_ESC);
      esc_state = 8'h00;
      if ((b < 8'h20 || b >= 8'h80) && b != KC_TAB && b != KC_CR) begin
        ctrl = 1'b1;
        code = b + 8'h40;           // wraps: 0xc0 gives code 0
        if (code == "J") begin
          ctrl = 1'b0;
          code = KC_CR;
        end
      end else if (b >= "A" && b <= "Z") begin
        shift = 1'b1;
      end else if (b >= "a" && b <= "z") begin
        code = b - 8'h20;
      end else if (shifted_digit_index(b) >= 0) begin
        shift = 1'b1;
        code  = "0" + 8'(shifted_digit_index(b));
      end else if (punct_index(b) >= 0) begin
        k     = punct_index(b);
        shift = (k >= 8);
        code  = PUNCT_BASE + 8'(k & 7);
      end else if (bracket_index(b) >= 0) begin
        k     = bracket_index(b);
        shift = (k >= 4);
        code  = BRACK_BASE + 8'(k & 3);
      end else if (b == KC_DEL) begin
        code = KC_BS;
      end
    end

    if (code == 8'h00) return 1'b0;

    // all-or-nothing: modifier makes, key make/break, modifier breaks
    need = (int'(alt) + int'(ctrl) + int'(shift) + 1) * 2;
    if (key_words.size() + need > KEY_SLOTS) return 1'b1;
    if (alt)   key_words.push_back({8'h00, ALT_MAKE});
    if (ctrl)  key_words.push_back({8'h00, CTRL_MAKE});
    if (shift) key_words.push_back({8'h00, SHIFT_MAKE});
    key_words.push_back({8'h00, code});
    key_words.push_back({code, 8'h00});
    if (shift) key_words.push_back({SHIFT_MAKE, 8'h00});
    if (ctrl)  key_words.push_back({CTRL_MAKE, 8'h00});
    if (alt)   key_words.push_back({ALT_MAKE, 8'h00});
    return 1'b0;
  endfunction

  function automatic logic [15:0] pop_key_word();
    if (key_words.size() == 0) return 16'h0000;
    return key_words.pop_front();
  endfunction

  // Empties the queue, OR-ing in a bit per WSADJK low byte seen
  function automatic logic [15:0] drain_directions();
    logic [15:0] bits;
    logic [15:0] w;
    bits = 16'h0000;
    while (key_words.size() > 0) begin
      w = key_words.pop_front();
      case (w[7:0])
        "W": bits |= 16'd32;
        "S": bits |= 16'd16;
        "A": bits |= 16'd8;
        "D": bits |= 16'd4;
        "J": bits |= 16'd2;
        "K": bits |= 16'd1;
        default: ;
      endcase
    end
    return bits;
  endfunction

  function automatic logic [15:0] bus_read_value(logic [7:0] addr, logic [2:0] size);
    logic [15:0] w;
    if (size == SIZE_BYTE) begin
      if (addr == ADDR_LCD) return 16'd1;
      if (addr == ADDR_KEY) begin
        w = pop_key_word();
        return {8'h00, w[7:0]};
      end
      if (addr == ADDR_OLDKEY) return drain_directions();
    end else if (size == SIZE_WORD && addr == ADDR_KEY) begin
      return pop_key_word();
    end
    return 16'h0000;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.action == ACT_TERM) r.dropped = translate_byte(it.term_byte);
    else r.read_data = bus_read_value(it.bus_address, it.access_size);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat driver
  // ---------------------------------------------------------------------------

  // Optional random gap, then hold start until the block takes the beat.
  // start stays high between back-to-back beats: one assignment per step.
  task automatic send_beat(in_item_t it);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(predict_result(it));
    sent_count++;
  endtask

  // Unused fields get random content
  task automatic send_term_byte(logic [7:0] b);
    in_item_t it;
    it.action      = ACT_TERM;
    it.term_byte   = b;
    it.bus_address = 8'($urandom_range(255));
    it.access_size = 3'($urandom_range(4, 1));
    send_beat(it);
  endtask

  task automatic send_bus_read(logic [7:0] addr, logic [2:0] size);
    in_item_t it;
    it.action      = ACT_READ;
    it.term_byte   = 8'($urandom_range(255));
    it.bus_address = addr;
    it.access_size = size;
    send_beat(it);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: done is a one-cycle strobe, compared against oldest entry
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: read_data %h dropped %b",
               result.read_data, result.dropped);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.read_data !== want.read_data) begin
          $error("read_data mismatch: expected %h, actual %h",
                 want.read_data, result.read_data);
          fail_count++;
        end
        if (result.dropped !== want.dropped) begin
          $error("dropped mismatch: expected %b, actual %b",
                 want.dropped, result.dropped);
          fail_count++;
        end
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reads on an empty queue, LCD status, and reads that do nothing
  task automatic test_empty_reads();
    send_bus_read(ADDR_KEY, SIZE_WORD);
    send_bus_read(ADDR_KEY, SIZE_BYTE);
    send_bus_read(ADDR_OLDKEY, SIZE_BYTE);
    send_bus_read(ADDR_LCD, SIZE_BYTE);
    send_bus_read(ADDR_KEY, SIZE_HALF);
    send_bus_read(ADDR_BOGUS, SIZE_BYTE);
  endtask

  // Plain byte mapping corners: NUL, top byte, code-zero ctrl, Ctrl-J, DEL, tab, Z, }
  task automatic test_plain_keys();
    send_term_byte(KC_NUL);
    send_term_byte(8'hff);
    send_term_byte(8'hc0);
    send_term_byte(KC_LF);
    send_term_byte(KC_DEL);
    send_term_byte(KC_TAB);
    send_term_byte("Z");
    send_term_byte("}");
  endtask

  // Double ESC, arrow, two-digit numeric code, ESC abandoning a CSI
  task automatic test_escape_sequences();
    send_term_byte(KC_ESC);
    send_term_byte(KC_ESC);
    send_term_byte(KC_CSI);   // ESC state still live after the double ESC
    send_term_byte("C");
    send_term_byte(KC_ESC);
    send_term_byte(KC_CSI);
    send_term_byte("7");
    send_term_byte("5");      // 7 mod 3 -> tens digit 1, code 15
    send_term_byte("q");      // terminator, consumed
    send_term_byte(KC_ESC);
    send_term_byte(KC_CSI);
    send_term_byte(KC_ESC);   // abandon, re-enter ESC state
    send_term_byte("x");      // alt-X
  endtask

  function automatic logic [7:0] pick_direction_byte();
    case ($urandom_range(11))
      0:  return "w";
      1:  return "a";
      2:  return "s";
      3:  return "d";
      4:  return "j";
      5:  return "k";
      6:  return "W";
      7:  return "A";
      8:  return "S";
      9:  return "D";
      10: return "J";
      default: return "K";
    endcase
  endfunction

  // Mostly key pops, some drains and status reads, some random offsets/sizes
  task automatic send_random_read();
    int r;
    r = $urandom_range(99);
    if (r < 45)      send_bus_read(ADDR_KEY, SIZE_WORD);
    else if (r < 70) send_bus_read(ADDR_KEY, SIZE_BYTE);
    else if (r < 78) send_bus_read(ADDR_OLDKEY, SIZE_BYTE);
    else if (r < 86) send_bus_read(ADDR_LCD, SIZE_BYTE);
    else             send_bus_read(8'($urandom_range(255)), 3'($urandom_range(4, 1)));
  endtask

  // Mostly well-formed sequences with random content; a share of noise
  task automatic send_random_key_sequence();
    int         extra;
    int         r;
    logic [7:0] b;
    case ($urandom_range(9))
      0: begin
        send_term_byte(KC_ESC);
        send_term_byte(KC_CSI);
        b = 8'("A" + $urandom_range(3));
        send_term_byte(b);
      end
      1: begin
        send_term_byte(KC_ESC);
        send_term_byte(KC_CSI);
        extra = $urandom_range(3);
        for (int i = 0; i <= extra; i++) begin
          b = 8'("0" + $urandom_range(9));
          send_term_byte(b);
        end
        r = $urandom_range(99);
        if (r < 70)      b = 8'($urandom_range(8'h7e, 8'h3a));
        else if (r < 85) b = 8'($urandom_range(255));
        else             b = KC_ESC;
        send_term_byte(b);
      end
      2: begin
        send_term_byte(KC_ESC);
        b = 8'($urandom_range(255));
        send_term_byte(b);
      end
      3: begin
        send_term_byte(KC_ESC);
        send_term_byte(KC_ESC);
      end
      4: begin
        send_term_byte(KC_ESC);
        send_term_byte(KC_CSI);
        b = 8'($urandom_range(255));
        send_term_byte(b);
      end
      5: send_term_byte(pick_direction_byte());
      6: begin
        b = 8'($urandom_range(8'h7e, 8'h20));
        send_term_byte(b);
      end
      7: begin
        b = 8'($urandom_range(8'h1f, 8'h01));
        send_term_byte(b);
      end
      8: begin
        b = 8'($urandom_range(255));
        send_term_byte(b);
      end
      default: begin
        b = 8'($urandom_range(8'hff, 8'h80));
        send_term_byte(b);
      end
    endcase
  endtask

  task automatic run_random_phase(int beats, int idle, int read_pct);
    int stop_at;
    idle_pct = idle;
    stop_at  = sent_count + beats;
    while (sent_count < stop_at) begin
      if ($urandom_range(99) < read_pct) send_random_read();
      else send_random_key_sequence();
    end
  endtask

  // Idle mixes: none, heavy, light, none; low read share lets the queue fill and drop
  task automatic test_random_traffic();
    run_random_phase(150, 0, 35);
    run_random_phase(150, 71, 45);
    run_random_phase(150, 25, 20);
    run_random_phase(150, 0, 55);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_reads();
    test_plain_keys();
    test_escape_sequences();
    test_random_traffic();

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
